@@ hdl/softmax_cross_entropy_loss_assert.svh @@
// Assertion macros for the softmax cross-entropy loss block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH
`define SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define SMCE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define SMCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMCE_ASSERT_SAME(label, ante, cons)
`define SMCE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/smce_pkg.sv @@
// Shared types and constants of the softmax cross-entropy loss block.
// No dependencies.
`timescale 1ns / 1ps
package smce_pkg;
    localparam int MAX_CLASSES = 63;
    localparam int MAX_BATCH   = 256;
    localparam int NUM_W       = 48;
    localparam int DEN_W       = 37;

    localparam logic [1:0] KIND_GRAD = 2'd0;
    localparam logic [1:0] KIND_LOSS = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
    localparam logic [1:0] REG_BATCH_COUNT = 2'd1;
    localparam logic [1:0] REG_EMIT_GRAD   = 2'd2;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // exp(-2^(k-8)) in Q0.32
    localparam logic [31:0] EXP_BITS [16] = '{
        32'd4278222805, 32'd4261543595, 32'd4228380001, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
        32'd483,        32'd0,          32'd0,          32'd0
    };

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_stat_t;
endpackage

@@ hdl/softmax_cross_entropy_loss.sv @@
// Softmax cross-entropy loss with gradient output, fixed point.
// Depends on smce_pkg, smce_div and softmax_cross_entropy_loss_assert.svh.
//
// Usage:
//   Write class_count (index 0), batch_count (1) and emit_gradients (2) through
//   cfg_write/cfg_addr/cfg_wdata while the block is idle; a write lands at once.
//   Feed logits (Q7.8) with start; a transaction is taken when start is high and
//   busy is low. target_class is sampled with the first logit of a sample.
//   Each logit takes one cycle. The last logit of a sample raises busy while a
//   sequencer drives one shared 32x32 multiplier and one bit-serial divider:
//     max scan        over the stored logits, one class at a time
//     exp             per class (16 multiply/round pairs)
//     target p, -ln   one divide, 16 squarings
//     gradients       per class (two divides)
//     mean loss       one divide at batch end
//   Results appear on kind/value/class_index/last for one cycle with strobe;
//   the receiver cannot stall, and every result is presented exactly once.
//   last marks the final result caused by one input transaction.
//   Reset clears all counters, the loss accumulator and the error flag and
//   returns the registers to 10 classes, batch of 1, gradients off.
`include "softmax_cross_entropy_loss_assert.svh"
`timescale 1ns / 1ps
module softmax_cross_entropy_loss (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_addr,
    input  logic [8:0]         cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] logit,
    input  logic [5:0]         target_class,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic signed [31:0] value,
    output logic [5:0]         class_index,
    output logic               last
);
    import smce_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_MAX_A     = 5'd1;
    localparam logic [4:0] S_MAX_B     = 5'd2;
    localparam logic [4:0] S_EXP_A     = 5'd3;
    localparam logic [4:0] S_EXP_INIT  = 5'd4;
    localparam logic [4:0] S_EXP_MUL   = 5'd5;
    localparam logic [4:0] S_EXP_ACC   = 5'd6;
    localparam logic [4:0] S_EXP_DONE  = 5'd7;
    localparam logic [4:0] S_P_A       = 5'd8;
    localparam logic [4:0] S_P_DIV     = 5'd9;
    localparam logic [4:0] S_P_WAIT    = 5'd10;
    localparam logic [4:0] S_LN_INIT   = 5'd11;
    localparam logic [4:0] S_LN_SQ_MUL = 5'd12;
    localparam logic [4:0] S_LN_SQ_ACC = 5'd13;
    localparam logic [4:0] S_LN_MUL    = 5'd14;
    localparam logic [4:0] S_LN_ACC    = 5'd15;
    localparam logic [4:0] S_G_A       = 5'd16;
    localparam logic [4:0] S_G_DIV     = 5'd17;
    localparam logic [4:0] S_G_WAIT    = 5'd18;
    localparam logic [4:0] S_G_MAG     = 5'd19;
    localparam logic [4:0] S_G_QWAIT   = 5'd20;
    localparam logic [4:0] S_FIN       = 5'd21;
    localparam logic [4:0] S_M_WAIT    = 5'd22;

    // control state
    logic [4:0] state_reg, state_next;
    logic [5:0] class_count_reg, class_count_next;
    logic [8:0] batch_count_reg, batch_count_next;
    logic       emit_reg, emit_next;
    logic [5:0] class_pos_reg, class_pos_next;
    logic [7:0] sample_pos_reg, sample_pos_next;
    logic [5:0] target_reg, target_next;
    logic [31:0] acc_reg, acc_next;
    logic       err_reg, err_next;
    logic [5:0] idx_reg, idx_next;
    logic [3:0] k_reg, k_next;
    logic       strobe_reg, strobe_next;

    // datapath
    logic signed [15:0] mx_reg, mx_next;
    logic [15:0] x_reg, x_next;
    logic [30:0] r_reg, r_next;
    logic [36:0] sum_reg, sum_next;
    logic [16:0] p_reg, p_next;
    logic [30:0] y_reg, y_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0]  n_reg, n_next;
    logic        neg_reg, neg_next;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] value_reg, value_next;
    logic [5:0]  cidx_reg, cidx_next;
    logic        last_reg, last_next;

    // memories
    logic signed [15:0] logit_mem [MAX_CLASSES];
    logic [30:0]        ex_mem [MAX_CLASSES];
    logic signed [15:0] logit_rd_reg;
    logic [30:0]        ex_rd_reg;

    logic        accept;
    logic [5:0]  cls;
    logic [8:0]  bat;
    logic [7:0]  half_b;
    logic        batch_end;
    logic        idx_last;
    logic        pos_more;
    logic [31:0] mul_a, mul_b;
    logic [63:0] rnd;
    logic [20:0] diff;
    logic [16:0] q17;
    logic [16:0] mag;
    logic [31:0] sq;
    logic [16:0] x_full;
    logic [4:0]  msb;
    div_req_t    div_req;
    div_stat_t   div_stat;

    smce_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .stat (div_stat)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // counts used clamped to their legal ranges
    assign cls = (class_count_reg == 6'd0) ? 6'd1 : class_count_reg;
    always_comb
    begin
        priority if (batch_count_reg == 9'd0)
            bat = 9'd1;
        else if (batch_count_reg > 9'(MAX_BATCH))
            bat = 9'(MAX_BATCH);
        else
            bat = batch_count_reg;
    end
    assign half_b    = bat[8:1];
    assign batch_end = ({1'b0, sample_pos_reg} + 9'd1) >= bat;
    assign idx_last  = ({1'b0, idx_reg} + 7'd1) >= {1'b0, cls};
    assign pos_more  = ({1'b0, class_pos_reg} + 7'd1) < {1'b0, cls};

    assign rnd    = prod_reg + 64'h0000_0000_8000_0000;
    assign diff   = 21'(32'd16 << 16) - {n_reg, frac_reg};
    assign q17    = div_stat.quot[16:0];
    assign mag    = (idx_reg == target_reg) ? (17'd65536 - q17) : q17;
    assign sq     = prod_reg[61:30];
    assign x_full = 17'(mx_reg) - 17'(logit_rd_reg);

    // highest set bit of the floored probability
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (p_reg[i])
            begin
                msb = 5'(i);
            end
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_EXP_MUL:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = EXP_BITS[k_reg];
            end
            S_LN_SQ_MUL:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, y_reg};
            end
            S_LN_MUL:
            begin
                mul_a = {11'd0, diff};
                mul_b = LN2_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod_next = 64'(mul_a) * 64'(mul_b);

    // divider request select
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = 37'(bat);
        unique case (state_reg)
            S_P_DIV, S_G_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = 48'({ex_rd_reg, 16'd0}) + 48'(sum_reg >> 1);
                div_req.den   = sum_reg;
            end
            S_G_MAG:
            begin
                div_req.start = 1'b1;
                div_req.num   = 48'(mag) + 48'(half_b);
            end
            S_FIN:
            begin
                div_req.start = batch_end && !err_reg;
                div_req.num   = 48'(acc_reg + 32'(half_b));
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        class_count_next = class_count_reg;
        batch_count_next = batch_count_reg;
        emit_next        = emit_reg;
        class_pos_next   = class_pos_reg;
        sample_pos_next  = sample_pos_reg;
        target_next      = target_reg;
        acc_next         = acc_reg;
        err_next         = err_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        strobe_next      = 1'b0;
        mx_next          = mx_reg;
        x_next           = x_reg;
        r_next           = r_reg;
        sum_next         = sum_reg;
        p_next           = p_reg;
        y_next           = y_reg;
        frac_next        = frac_reg;
        n_next           = n_reg;
        neg_next         = neg_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        cidx_next        = cidx_reg;
        last_next        = last_reg;

        if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_CLASS_COUNT: class_count_next = cfg_wdata[5:0];
                REG_BATCH_COUNT: batch_count_next = cfg_wdata;
                REG_EMIT_GRAD:   emit_next        = cfg_wdata[0];
                default:         emit_next        = emit_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (class_pos_reg == 6'd0)
                    begin
                        target_next = target_class;
                    end
                    if (pos_more)
                    begin
                        class_pos_next = class_pos_reg + 6'd1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        mx_next    = 16'sh8000;
                        state_next = S_MAX_A;
                    end
                end
            end
            S_MAX_A:
            begin
                state_next = S_MAX_B;
            end
            S_MAX_B:
            begin
                if (logit_rd_reg > mx_reg)
                begin
                    mx_next = logit_rd_reg;
                end
                if (idx_last)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_EXP_A;
                end
                else
                begin
                    idx_next   = idx_reg + 6'd1;
                    state_next = S_MAX_A;
                end
            end
            S_EXP_A:
            begin
                state_next = S_EXP_INIT;
            end
            S_EXP_INIT:
            begin
                x_next     = x_full[15:0];
                r_next     = ONE_Q30;
                k_next     = '0;
                state_next = S_EXP_MUL;
            end
            S_EXP_MUL:
            begin
                state_next = S_EXP_ACC;
            end
            S_EXP_ACC:
            begin
                if (x_reg[k_reg])
                begin
                    r_next = rnd[62:32];
                end
                if (k_reg == 4'd15)
                begin
                    state_next = S_EXP_DONE;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_EXP_MUL;
                end
            end
            S_EXP_DONE:
            begin
                sum_next = sum_reg + 37'(r_reg);
                if (idx_last)
                begin
                    if (target_reg < cls)
                    begin
                        idx_next   = target_reg;
                        state_next = S_P_A;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 6'd1;
                    state_next = S_EXP_A;
                end
            end
            S_P_A:
            begin
                state_next = S_P_DIV;
            end
            S_P_DIV:
            begin
                state_next = S_P_WAIT;
            end
            S_P_WAIT:
            begin
                if (div_stat.done)
                begin
                    // floor at one probability LSB
                    p_next     = (q17 == 17'd0) ? 17'd1 : q17;
                    state_next = S_LN_INIT;
                end
            end
            S_LN_INIT:
            begin
                n_next     = msb;
                y_next     = 31'(p_reg) << (5'd30 - msb);
                frac_next  = '0;
                k_next     = '0;
                state_next = S_LN_SQ_MUL;
            end
            S_LN_SQ_MUL:
            begin
                state_next = S_LN_SQ_ACC;
            end
            S_LN_SQ_ACC:
            begin
                if (sq[31])
                begin
                    y_next = sq[31:1];
                    frac_next[4'd15 - k_reg] = 1'b1;
                end
                else
                begin
                    y_next = sq[30:0];
                end
                if (k_reg == 4'd15)
                begin
                    state_next = S_LN_MUL;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_LN_SQ_MUL;
                end
            end
            S_LN_MUL:
            begin
                state_next = S_LN_ACC;
            end
            S_LN_ACC:
            begin
                acc_next = acc_reg + rnd[63:32];
                if (emit_reg)
                begin
                    idx_next   = '0;
                    state_next = S_G_A;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_G_A:
            begin
                state_next = S_G_DIV;
            end
            S_G_DIV:
            begin
                state_next = S_G_WAIT;
            end
            S_G_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_G_MAG;
                end
            end
            S_G_MAG:
            begin
                neg_next   = (idx_reg == target_reg) && (mag != 17'd0);
                state_next = S_G_QWAIT;
            end
            S_G_QWAIT:
            begin
                if (div_stat.done)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_GRAD;
                    value_next  = neg_reg ? (32'd0 - 32'(q17)) : 32'(q17);
                    cidx_next   = idx_reg;
                    last_next   = idx_last && !batch_end;
                    if (idx_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = S_G_A;
                    end
                end
            end
            S_FIN:
            begin
                class_pos_next = '0;
                if (batch_end)
                begin
                    if (err_reg)
                    begin
                        strobe_next     = 1'b1;
                        kind_next       = KIND_ERR;
                        value_next      = '0;
                        cidx_next       = '0;
                        last_next       = 1'b1;
                        sample_pos_next = '0;
                        acc_next        = '0;
                        err_next        = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_M_WAIT;
                    end
                end
                else
                begin
                    sample_pos_next = sample_pos_reg + 8'd1;
                    state_next      = S_IDLE;
                end
            end
            S_M_WAIT:
            begin
                if (div_stat.done)
                begin
                    strobe_next     = 1'b1;
                    kind_next       = KIND_LOSS;
                    value_next      = div_stat.quot[31:0];
                    cidx_next       = '0;
                    last_next       = 1'b1;
                    sample_pos_next = '0;
                    acc_next        = '0;
                    err_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            class_count_reg <= 6'd10;
            batch_count_reg <= 9'd1;
            emit_reg        <= 1'b0;
            class_pos_reg   <= '0;
            sample_pos_reg  <= '0;
            target_reg      <= '0;
            acc_reg         <= '0;
            err_reg         <= 1'b0;
            idx_reg         <= '0;
            k_reg           <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            class_count_reg <= class_count_next;
            batch_count_reg <= batch_count_next;
            emit_reg        <= emit_next;
            class_pos_reg   <= class_pos_next;
            sample_pos_reg  <= sample_pos_next;
            target_reg      <= target_next;
            acc_reg         <= acc_next;
            err_reg         <= err_next;
            idx_reg         <= idx_next;
            k_reg           <= k_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= mx_next;
        x_reg     <= x_next;
        r_reg     <= r_next;
        sum_reg   <= sum_next;
        p_reg     <= p_next;
        y_reg     <= y_next;
        frac_reg  <= frac_next;
        n_reg     <= n_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        cidx_reg  <= cidx_next;
        last_reg  <= last_next;
    end

    // logit store: write on accept, read at the sequencer index
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            logit_mem[class_pos_reg] <= logit;
        end
        logit_rd_reg <= logit_mem[idx_reg];
    end

    // exponential store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXP_DONE)
        begin
            ex_mem[idx_reg] <= r_reg;
        end
        ex_rd_reg <= ex_mem[idx_reg];
    end

    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign value       = value_reg;
    assign class_index = cidx_reg;
    assign last        = last_reg;

    // a result only follows a cycle of sample processing
    `SMCE_ASSERT_SAME(a_strobe_after_work, strobe_reg, $past(state_reg != S_IDLE))
    // gradients name a class inside the current sample
    `SMCE_ASSERT_SAME(a_grad_class_range, strobe_reg && (kind_reg == KIND_GRAD),
                      cidx_reg < cls)
    // the divider is never restarted while it iterates
    `SMCE_ASSERT_SAME(a_div_free, div_req.start, !div_stat.busy)
    // a batch-end result clears the accumulator, the error flag and the sample count
    `SMCE_ASSERT_NEXT(a_batch_clear, strobe_reg && (kind_reg != KIND_GRAD) && last_reg,
                      (acc_reg == 32'd0) && !err_reg && (sample_pos_reg == 8'd0))
endmodule

@@ hdl/smce_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on smce_pkg.
`timescale 1ns / 1ps
module smce_div (
    input  logic                clk,
    input  logic                rst_n,
    input  smce_pkg::div_req_t  req,
    output smce_pkg::div_stat_t stat
);
    import smce_pkg::*;

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            den_next  = req.den;
            num_next  = req.num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next  = rem_sub[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;
endmodule
